>>> rtl/core/mdq_pkg.sv
// Shared types and constants for the mouse delta to quadrature core.
// No dependencies; imported by mdq_axis and mouse_delta_to_quadrature_core.
`default_nettype none

package mdq_pkg;

  // Item kinds on the input channel
  typedef enum logic {
    OP_REPORT = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  localparam int unsigned DELTA_W  = 8;
  localparam int unsigned STEPS_W  = 8;
  localparam int unsigned PHASE_W  = 2;
  localparam int unsigned BUTTON_W = 3;

  localparam logic [PHASE_W-1:0]  PHASE_RST    = 2'd3;
  localparam logic [BUTTON_W-1:0] BTN_RELEASED = 3'b111;

  // Quadrature phase tables indexed by phase 0..3
  localparam logic [3:0] PHASE_A_TAB = 4'b1100;
  localparam logic [3:0] PHASE_B_TAB = 4'b0110;

  // Per-axis values after an item, seen by the top level
  typedef struct packed {
    logic pin_a;
    logic pin_b;
    logic busy;
  } axis_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/mouse_delta_to_quadrature_core.sv
// Top level of the mouse delta to quadrature core: input register, two axes,
// button lines and result register. Depends on mdq_pkg and mdq_axis.
`default_nettype none

// Takes mouse reports and step ticks and returns one result beat per item
// with the four quadrature pin levels, the active-low button lines and a
// busy flag that is high while either axis still has steps to emit. A new
// item is taken every cycle as long as the result side keeps taking beats;
// each item is held in the input register and is then written to the result
// register, and throughput is one item per cycle under that same condition.
// A report replaces any pending steps; a tick moves each busy axis one phase
// along the 00-01-11-10 pattern.

module mouse_delta_to_quadrature_core
  import mdq_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // input channel
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_op,
  input  wire logic [BUTTON_W-1:0]        in_button_bits,
  input  wire logic signed [DELTA_W-1:0]  in_delta_x,
  input  wire logic signed [DELTA_W-1:0]  in_delta_y,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_h_pulse,
  output logic                            out_hq_pulse,
  output logic                            out_v_pulse,
  output logic                            out_vq_pulse,
  output logic [BUTTON_W-1:0]             out_button_lines,
  output logic                            out_busy_res
);

  // input register
  logic                       stage_v_r;
  op_t                        stage_op_r;
  logic [BUTTON_W-1:0]        stage_btn_r;
  logic signed [DELTA_W-1:0]  stage_dx_r;
  logic signed [DELTA_W-1:0]  stage_dy_r;

  // button state
  logic [BUTTON_W-1:0]        btn_r, btn_nxt;

  // result register
  logic                       out_v_r;
  logic                       h_r, hq_r, v_r, vq_r, busy_r;
  logic [BUTTON_W-1:0]        btn_out_r;

  logic                       adv;
  logic                       in_fire;
  axis_stat_t                 x_nxt, x_cur, y_nxt, y_cur;

  // Apply the staged item when the result register is free or draining
  assign adv      = stage_v_r && (!out_v_r || out_ready);
  assign in_ready = !stage_v_r || adv;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (in_ready) begin
      stage_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_op_r  <= op_t'(in_op);
      stage_btn_r <= in_button_bits;
      stage_dx_r  <= in_delta_x;
      stage_dy_r  <= in_delta_y;
    end
  end

  // Horizontal: positive direction steps phase down
  mdq_axis u_axis_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .op       (stage_op_r),
    .delta    (stage_dx_r),
    .pos_up   (1'b0),
    .stat_nxt (x_nxt),
    .stat_cur (x_cur)
  );

  // Vertical: positive direction steps phase up
  mdq_axis u_axis_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .op       (stage_op_r),
    .delta    (stage_dy_r),
    .pos_up   (1'b1),
    .stat_nxt (y_nxt),
    .stat_cur (y_cur)
  );

  // Buttons follow each report, active low
  always_comb begin
    btn_nxt = btn_r;
    if (adv && stage_op_r == OP_REPORT) begin
      btn_nxt = ~stage_btn_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      btn_r <= BTN_RELEASED;
    end else begin
      btn_r <= btn_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_r       <= x_nxt.pin_a;
      hq_r      <= x_nxt.pin_b;
      v_r       <= y_nxt.pin_a;
      vq_r      <= y_nxt.pin_b;
      btn_out_r <= btn_nxt;
      busy_r    <= x_nxt.busy || y_nxt.busy;
    end
  end

  assign out_valid        = out_v_r;
  assign out_h_pulse      = h_r;
  assign out_hq_pulse     = hq_r;
  assign out_v_pulse      = v_r;
  assign out_vq_pulse     = vq_r;
  assign out_button_lines = btn_out_r;
  assign out_busy_res     = busy_r;

  // A report never moves the pins
  a_report_keeps_pins: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && stage_op_r == OP_REPORT)
      |=> (out_h_pulse == $past(x_cur.pin_a)) && (out_hq_pulse == $past(x_cur.pin_b))
       && (out_v_pulse == $past(y_cur.pin_a)) && (out_vq_pulse == $past(y_cur.pin_b)))
    else $error("report changed quadrature pins");

  // A report with zero deltas leaves both axes idle
  a_zero_report_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && stage_op_r == OP_REPORT && stage_dx_r == '0 && stage_dy_r == '0)
      |=> (out_valid && !out_busy_res))
    else $error("zero report left an axis busy");

  // Busy in the result matches the axis counters right after an item
  a_busy_tracks_axes: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (out_busy_res == (x_cur.busy || y_cur.busy)))
    else $error("busy flag out of step with axis counters");

  // Stalling the input only happens with a held item and a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (stage_v_r && out_v_r && !out_ready))
    else $error("input stalled without cause");

endmodule

`default_nettype wire

>>> rtl/core/mdq_axis.sv
// One quadrature axis: step count, direction, phase and pin levels.
// Depends on mdq_pkg.
`default_nettype none

module mdq_axis
  import mdq_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      adv,         // item applied this cycle
  input  wire op_t                       op,
  input  wire logic signed [DELTA_W-1:0] delta,
  input  wire logic                      pos_up,      // positive direction steps phase up
  output axis_stat_t                     stat_nxt,    // values after this item
  output axis_stat_t                     stat_cur     // values held now
);

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [STEPS_W-1:0] steps_r, steps_nxt;
  logic               pos_r, pos_nxt;
  logic               pin_a_r, pin_a_nxt;
  logic               pin_b_r, pin_b_nxt;
  logic [STEPS_W-1:0] mag;
  logic               step_up;

  // Magnitude of the signed delta; -128 maps to 128
  assign mag = delta[DELTA_W-1] ? STEPS_W'(~delta + 1'b1) : STEPS_W'(delta);

  assign step_up = (pos_r == pos_up);

  // Report loads count and direction; tick steps a busy axis
  always_comb begin
    phase_nxt = phase_r;
    steps_nxt = steps_r;
    pos_nxt   = pos_r;
    pin_a_nxt = pin_a_r;
    pin_b_nxt = pin_b_r;
    if (adv) begin
      case (op)
        OP_REPORT: begin
          steps_nxt = mag;
          pos_nxt   = !delta[DELTA_W-1] && (delta != '0);
        end
        OP_TICK: begin
          if (steps_r != '0) begin
            pin_a_nxt = PHASE_A_TAB[phase_r];
            pin_b_nxt = PHASE_B_TAB[phase_r];
            phase_nxt = step_up ? phase_r + 1'b1 : phase_r - 1'b1;
            steps_nxt = steps_r - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_RST;
      steps_r <= '0;
      pos_r   <= 1'b0;
      pin_a_r <= 1'b0;
      pin_b_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      steps_r <= steps_nxt;
      pos_r   <= pos_nxt;
      pin_a_r <= pin_a_nxt;
      pin_b_r <= pin_b_nxt;
    end
  end

  assign stat_nxt = '{pin_a: pin_a_nxt, pin_b: pin_b_nxt, busy: (steps_nxt != '0)};
  assign stat_cur = '{pin_a: pin_a_r, pin_b: pin_b_r, busy: (steps_r != '0)};

endmodule

`default_nettype wire
